// ===== sv/swst_pkg.sv =====
// Shared types and constants for the sample window statistics block.
package swst_pkg;

    localparam int IDX_W      = 5;
    localparam int SMP_W      = 16;
    localparam int VAR_W      = 32;
    localparam int ROOT_STEPS = VAR_W / 2;

    // Engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MDIV,
        ST_SQ,
        ST_VDIV,
        ST_ROOT,
        ST_DONE
    } eng_state_t;

    // One classified transaction waiting in the queue
    typedef struct packed {
        logic                    hit;
        logic [IDX_W-1:0]        index;
        logic signed [SMP_W-1:0] value;
    } sample_item_t;

    // One finished result
    typedef struct packed {
        logic signed [SMP_W-1:0] mean;
        logic [VAR_W-1:0]        variance;
        logic [SMP_W-1:0]        deviation;
        logic signed [SMP_W-1:0] maxv;
        logic signed [SMP_W-1:0] minv;
        logic [SMP_W-1:0]        span;
    } stats_t;

endpackage

// ===== sv/swst_front.sv =====
// Input side: accepts transactions, checks the slot range, and queues them.
module swst_front
    import swst_pkg::*;
#(
    parameter int SIZE = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IDX_W-1:0]        sample_index,
    input  logic signed [SMP_W-1:0] sample_value,
    output logic                    q_valid,
    output sample_item_t            q_item,
    input  logic                    q_pop
);

    sample_item_t entries_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    sample_item_t push_item;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entries_reg[rd_ptr_reg];

    // Classify: slots beyond the store leave it unchanged
    always_comb
    begin
        push_item.hit   = ({{(32-IDX_W){1'b0}}, sample_index} < 32'(SIZE));
        push_item.index = sample_index;
        push_item.value = sample_value;
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== sv/swst_div.sv =====
// Division by a fixed constant, eight dividend bits per step via a reciprocal.
module swst_div
#(
    parameter int DW      = 41,
    parameter int DIVISOR = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [DW-1:0] quotient
);

    // Each step divides {remainder, next byte}, always below 2^16, by the constant
    localparam int DGW = 8;
    localparam int NC  = (DW + DGW - 1) / DGW;
    localparam int PW  = NC * DGW;
    localparam int XW  = 2 * DGW;
    localparam int SH  = XW + $clog2(DIVISOR);
    localparam int MW  = XW + 2;
    localparam int PRW = XW + MW;
    localparam int CW  = $clog2(NC + 1);
    localparam longint RECIP =
        ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

    logic [PW-1:0]  work_reg;
    logic [DGW-1:0] rem_reg;
    logic [XW-1:0]  x_reg;
    logic [PRW-1:0] prod_reg;
    logic [CW-1:0]  cnt_reg;
    logic           run_reg;
    logic           phase_reg;
    logic           done_reg;
    logic [XW-1:0]  x_cur;
    logic [DGW-1:0] digit;
    logic [XW-1:0]  back;
    logic [XW-1:0]  rem_full;

    // Quotient digit from the registered product, remainder by constant multiply
    always_comb
    begin
        x_cur    = {rem_reg, work_reg[PW-1 -: DGW]};
        digit    = prod_reg[SH +: DGW];
        back     = XW'(digit) * XW'(DIVISOR);
        rem_full = x_reg - back;
    end

    // Quotient digits shift in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= PW'(dividend);
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            if (!phase_reg)
            begin
                x_reg    <= x_cur;
                prod_reg <= PRW'(x_cur) * PRW'(RECIP_C);
            end
            else
            begin
                work_reg <= {work_reg[PW-DGW-1:0], digit};
                rem_reg  <= rem_full[DGW-1:0];
            end
        end
    end

    // Step sequencing: multiply phase, then digit and remainder phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg   <= CW'(NC);
                run_reg   <= 1'b1;
                phase_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                phase_reg <= !phase_reg;
                if (phase_reg)
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[DW-1:0];

endmodule

// ===== sv/swst_engine.sv =====
// Back end: sample store, two passes over it, divisions, square root, result register.
module swst_engine
    import swst_pkg::*;
#(
    parameter int SIZE = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  sample_item_t q_item,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_stall,
    output stats_t       result
);

    localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int CW = $clog2(SIZE + 1);
    localparam int SW = SMP_W + AW + 1;
    localparam int QW = 2 * SMP_W + AW + 1;
    localparam int RCW = $clog2(ROOT_STEPS + 1);

    eng_state_t state_reg;
    eng_state_t state_next;

    // Store and its reset-valid bits
    logic signed [SMP_W-1:0] mem [SIZE];
    logic [SIZE-1:0]         vld_reg;
    logic [IDX_W+AW-1:0]     wr_wide;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;

    logic [CW-1:0]           ic_reg;
    logic                    issue;
    logic                    rdv_reg;
    logic signed [SMP_W-1:0] rd_data_reg;
    logic                    rd_hit_reg;
    logic signed [SMP_W-1:0] smp;

    logic signed [SW-1:0]    sum_reg;
    logic signed [SMP_W-1:0] hi_reg;
    logic signed [SMP_W-1:0] lo_reg;
    logic                    first_reg;
    logic signed [SMP_W-1:0] mean_reg;
    logic signed [SMP_W:0]   diff;
    logic [SMP_W:0]          diff_mag;
    logic [2*SMP_W-1:0]      sq_reg;
    logic                    sqv_reg;
    logic [QW-1:0]           acc_reg;
    logic [SW-1:0]           sum_mag;

    logic                    div_start;
    logic [QW-1:0]           div_in;
    logic                    div_done;
    logic [QW-1:0]           div_q;
    logic [SMP_W-1:0]        q_low;

    logic [VAR_W-1:0]        var_reg;
    logic [VAR_W-1:0]        rt_rem_reg;
    logic [VAR_W-1:0]        rt_root_reg;
    logic [VAR_W-1:0]        rt_bit_reg;
    logic [RCW-1:0]          rt_cnt_reg;
    logic [VAR_W-1:0]        rt_trial;

    logic                    out_load;
    logic                    out_valid_reg;
    stats_t                  stats_reg;

    assign wr_wide = {{AW{1'b0}}, q_item.index};
    assign wr_addr = wr_wide[AW-1:0];
    assign rd_addr = ic_reg[AW-1:0];
    assign wr_en   = q_pop && q_item.hit;
    assign issue   = ((state_reg == ST_SUM) || (state_reg == ST_SQ)) && (ic_reg != CW'(SIZE));
    assign smp     = rd_hit_reg ? rd_data_reg : '0;
    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign q_low   = div_q[SMP_W-1:0];
    assign rt_trial = rt_root_reg + rt_bit_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        div_in     = acc_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                div_in = {{(QW-SW){1'b0}}, sum_mag};
                if ((ic_reg == CW'(SIZE)) && !rdv_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if ((ic_reg == CW'(SIZE)) && !rdv_reg && !sqv_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_VDIV;
                end
            end
            ST_VDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rt_cnt_reg == RCW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_item.value;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= vld_reg[rd_addr];
        end
    end

    // Entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Pass control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg  <= '0;
            rdv_reg <= 1'b0;
            sqv_reg <= 1'b0;
        end
        else
        begin
            rdv_reg <= issue;
            sqv_reg <= rdv_reg && (state_reg == ST_SQ);
            if ((state_reg == ST_IDLE) || (state_reg == ST_MDIV))
            begin
                ic_reg <= '0;
            end
            else if (issue)
            begin
                ic_reg <= ic_reg + CW'(1);
            end
        end
    end

    // Deviation from the truncated mean
    always_comb
    begin
        diff     = {mean_reg[SMP_W-1], mean_reg} - {smp[SMP_W-1], smp};
        diff_mag = diff[SMP_W] ? (SMP_W+1)'(-diff) : (SMP_W+1)'(diff);
    end

    // Accumulators, mean and square root
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            sum_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if ((state_reg == ST_SUM) && rdv_reg)
        begin
            sum_reg   <= sum_reg + SW'(smp);
            first_reg <= 1'b0;
            if (first_reg || (smp > hi_reg))
            begin
                hi_reg <= smp;
            end
            if (first_reg || (smp < lo_reg))
            begin
                lo_reg <= smp;
            end
        end

        if ((state_reg == ST_MDIV) && div_done)
        begin
            mean_reg <= sum_reg[SW-1] ? SMP_W'(-q_low) : q_low;
        end

        if (rdv_reg)
        begin
            sq_reg <= diff_mag[SMP_W-1:0] * diff_mag[SMP_W-1:0];
        end

        if (state_reg == ST_MDIV)
        begin
            acc_reg <= '0;
        end
        else if (sqv_reg)
        begin
            acc_reg <= acc_reg + QW'(sq_reg);
        end

        // Digit-by-digit root, two radicand bits per step
        if ((state_reg == ST_VDIV) && div_done)
        begin
            var_reg     <= div_q[VAR_W-1:0];
            rt_rem_reg  <= div_q[VAR_W-1:0];
            rt_root_reg <= '0;
            rt_bit_reg  <= VAR_W'(1) << (VAR_W - 2);
            rt_cnt_reg  <= RCW'(ROOT_STEPS);
        end
        else if (state_reg == ST_ROOT)
        begin
            if (rt_rem_reg >= rt_trial)
            begin
                rt_rem_reg  <= rt_rem_reg - rt_trial;
                rt_root_reg <= (rt_root_reg >> 1) + rt_bit_reg;
            end
            else
            begin
                rt_root_reg <= rt_root_reg >> 1;
            end
            rt_bit_reg <= rt_bit_reg >> 2;
            rt_cnt_reg <= rt_cnt_reg - RCW'(1);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            stats_reg.mean      <= mean_reg;
            stats_reg.variance  <= var_reg;
            stats_reg.deviation <= rt_root_reg[SMP_W-1:0];
            stats_reg.maxv      <= hi_reg;
            stats_reg.minv      <= lo_reg;
            stats_reg.span      <= SMP_W'(hi_reg - lo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = stats_reg;

    swst_div #(
        .DW      (QW),
        .DIVISOR (SIZE)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

// ===== sv/sample_window_statistics.sv =====
// Top level of the sample window statistics block.
// Keeps SIZE signed Q11.4 samples (zero after reset); each input transaction
// overwrites one slot (slots at or beyond SIZE are ignored) and yields one
// result: mean, variance (Q.8), standard deviation (Q.4), max, min and span
// over the whole store. Inputs queue two deep ahead of a back end that works on
// one transaction at a time and, once done, holds off while the previous result
// still waits on out_stall. Each transaction takes a read pass for sum, max and
// min, a division by SIZE for the mean (reciprocal multiply on a QW-bit dividend,
// QW = 2*SMP_W + ceil(log2(SIZE)) + 1 = 38 at SIZE = 24, eight dividend bits per
// step), a second pass for squared deviations, a second division for the
// variance and a 16-step square root.
module sample_window_statistics
    import swst_pkg::*;
#(
    parameter int SIZE = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IDX_W-1:0]        sample_index,
    input  logic signed [SMP_W-1:0] sample_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SMP_W-1:0] mean_value,
    output logic [VAR_W-1:0]        variance_value,
    output logic [SMP_W-1:0]        deviation_value,
    output logic signed [SMP_W-1:0] max_value,
    output logic signed [SMP_W-1:0] min_value,
    output logic [SMP_W-1:0]        span_value
);

    logic         q_valid;
    logic         q_pop;
    sample_item_t q_item;
    stats_t       result;

    swst_front #(
        .SIZE (SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    swst_engine #(
        .SIZE (SIZE)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // Unpack the result transaction
    assign mean_value      = result.mean;
    assign variance_value  = result.variance;
    assign deviation_value = result.deviation;
    assign max_value       = result.maxv;
    assign min_value       = result.minv;
    assign span_value      = result.span;

endmodule
